/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on the rising edge with a
// synchronous active-high reset as the disable condition
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OWRR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OWRR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/owrr_pkg.sv */
// ----------------------------------------------------------------------------
// owrr_pkg
// shared types, constants and the request crc for the one-wire
// request/reply master
// ----------------------------------------------------------------------------
package owrr_pkg;

   // default frame lengths
   localparam int REQUEST_BITS_DEF = 16;
   localparam int REPLY_BITS_DEF   = 32;

   // tick counter width, holds up to 63
   localparam int CNT_W = 6;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int SHIFT_W = 32;

   // crc-8, msb first, no reflection, no final xor
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hAC;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

   // lengths of the fixed phases, in ticks
   localparam logic [CNT_W-1:0] START_TICKS = 6'd1;
   localparam logic [CNT_W-1:0] WAIT_TICKS  = 6'd2;
   localparam logic [CNT_W-1:0] STOP_TICKS  = 6'd2;

   // tick count at which the line is released during the wait phase
   localparam logic [CNT_W-1:0] RELEASE_AT = 6'd1;

   // item opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] request_byte;
      logic              line_sample;
   } item_type;

   typedef struct packed {
      logic               line_level;
      logic               line_output_enable;
      logic               busy_res;
      logic               reply_valid;
      logic [SHIFT_W-1:0] reply_data;
   } result_type;

   function automatic logic [BYTE_W-1:0] crc8_of_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = CRC_INIT ^ b;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* design/owrr_seq.sv */
// ----------------------------------------------------------------------------
// owrr_seq
// exchange sequencer: applies one item to the phase state and registers
// the matching result
// ----------------------------------------------------------------------------
module owrr_seq #(
   parameter int REQUEST_BITS = owrr_pkg::REQUEST_BITS_DEF,
   parameter int REPLY_BITS   = owrr_pkg::REPLY_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  owrr_pkg::item_type     item,
   output owrr_pkg::result_type   result
);

   localparam logic [owrr_pkg::CNT_W-1:0] REQ_COUNT = owrr_pkg::CNT_W'(REQUEST_BITS);
   localparam logic [owrr_pkg::CNT_W-1:0] RPL_COUNT = owrr_pkg::CNT_W'(REPLY_BITS);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_START    = 3'd1,
      PH_REQUEST  = 3'd2,
      PH_WAITING  = 3'd3,
      PH_RESPONSE = 3'd4,
      PH_STOPPING = 3'd5
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [owrr_pkg::CNT_W-1:0]        tick_ff, tick_in, tick_dec;
   logic [owrr_pkg::SHIFT_W-1:0]      shift_ff, shift_in, shift_rx;
   logic                              level_ff, level_in;
   logic                              enable_ff, enable_in;
   logic                              valid_in;
   logic [owrr_pkg::SHIFT_W-1:0]      data_in;
   owrr_pkg::result_type              result_ff, result_in;

   assign tick_dec = tick_ff - owrr_pkg::CNT_W'(1);
   assign shift_rx = {shift_ff[owrr_pkg::SHIFT_W-2:0], item.line_sample};

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      shift_in  = shift_ff;
      level_in  = level_ff;
      enable_in = enable_ff;
      valid_in  = 1'b0;
      data_in   = '0;
      if (item.opcode == owrr_pkg::OP_START) begin
         phase_in  = PH_START;
         shift_in  = {item.request_byte, owrr_pkg::crc8_of_byte(item.request_byte),
                      {(owrr_pkg::SHIFT_W - 2*owrr_pkg::BYTE_W){1'b0}}};
         tick_in   = owrr_pkg::START_TICKS;
         enable_in = 1'b1;
         level_in  = 1'b0;
      end else begin
         tick_in = tick_dec;
         unique case (phase_ff)
            PH_START: begin
               if (tick_dec == '0) begin
                  tick_in  = REQ_COUNT;
                  phase_in = PH_REQUEST;
               end
            end
            PH_REQUEST: begin
               // msb goes out first
               level_in = shift_ff[owrr_pkg::SHIFT_W-1];
               shift_in = {shift_ff[owrr_pkg::SHIFT_W-2:0], 1'b0};
               if (tick_dec == '0) begin
                  tick_in  = owrr_pkg::WAIT_TICKS;
                  phase_in = PH_WAITING;
               end
            end
            PH_WAITING: begin
               if (tick_dec == '0) begin
                  tick_in  = RPL_COUNT;
                  phase_in = PH_RESPONSE;
               end
               // release the line one tick before the reply starts
               if (tick_dec == owrr_pkg::RELEASE_AT) begin
                  enable_in = 1'b0;
                  level_in  = 1'b1;
               end
            end
            PH_RESPONSE: begin
               shift_in = shift_rx;
               if (tick_dec == '0) begin
                  tick_in   = owrr_pkg::STOP_TICKS;
                  phase_in  = PH_STOPPING;
                  level_in  = 1'b1;
                  enable_in = 1'b1;
                  valid_in  = 1'b1;
                  data_in   = shift_rx;
               end
            end
            PH_STOPPING: begin
               if (tick_dec == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
      result_in.line_level         = level_in;
      result_in.line_output_enable = enable_in;
      result_in.busy_res           = (phase_in != PH_IDLE);
      result_in.reply_valid        = valid_in;
      result_in.reply_data         = data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         shift_ff  <= '0;
         level_ff  <= 1'b1;
         enable_ff <= 1'b1;
         result_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         shift_ff  <= shift_in;
         level_ff  <= level_in;
         enable_ff <= enable_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* design/one_wire_request_reply_master_top.sv */
// ----------------------------------------------------------------------------
// one_wire_request_reply_master_top
// master for a single-line request/reply exchange stepped by timer ticks
// ----------------------------------------------------------------------------
// Each request word is either a start (request byte in) or one timer tick.
// A start computes the crc-8 of the request byte (poly 0x07, init 0xAC),
// loads byte and crc into the shift register and drives the line low; later
// ticks run one start tick, the request bits msb first, two wait ticks (the
// line is released on the first), the reply bits sampled msb first, and two
// stop ticks. A start always restarts the exchange. Every request word gives
// exactly one response word showing the line controls and busy flag after
// that step; reply_valid marks the word holding the complete reply, and
// reply_data is zero otherwise. Throughput is one word per clock: the whole
// step is a small next-state cone between the sequencer state and a single
// response register, and a new word is taken whenever that register is empty
// or being read in the same cycle. rsp_valid rises in the cycle after
// acceptance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module one_wire_request_reply_master_top #(
   parameter int REQUEST_BITS = owrr_pkg::REQUEST_BITS_DEF,
   parameter int REPLY_BITS   = owrr_pkg::REPLY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [owrr_pkg::BYTE_W-1:0]       req_request_byte,
   input  logic                              req_line_sample,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_line_level,
   output logic                              rsp_line_output_enable,
   output logic                              rsp_busy_res,
   output logic                              rsp_reply_valid,
   output logic [owrr_pkg::SHIFT_W-1:0]      rsp_reply_data
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_accept;
   owrr_pkg::item_type    item;
   owrr_pkg::result_type  result;

   // take a word when the response slot is free or drains this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign item.opcode       = req_opcode;
   assign item.request_byte = req_request_byte;
   assign item.line_sample  = req_line_sample;

   // sequencer state plus the response payload register
   owrr_seq #(
      .REQUEST_BITS (REQUEST_BITS),
      .REPLY_BITS   (REPLY_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .item    (item),
      .result  (result)
   );

   // response slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_line_level         = result.line_level;
   assign rsp_line_output_enable = result.line_output_enable;
   assign rsp_busy_res           = result.busy_res;
   assign rsp_reply_valid        = result.reply_valid;
   assign rsp_reply_data         = result.reply_data;

   // a start word always leaves the line driven low and the block busy
   `OWRR_ASSERT_NEXT(a_start_drives_low, clock, reset, req_accept && req_opcode == owrr_pkg::OP_START, rsp_valid && rsp_busy_res && rsp_line_output_enable && !rsp_line_level, "start did not drive the line low")
   // the complete reply comes with the line driven high again
   `OWRR_ASSERT_NOW(a_reply_line_high, clock, reset, rsp_valid && rsp_reply_valid, rsp_busy_res && rsp_line_output_enable && rsp_line_level, "reply without line driven high")
   // reply data is zero outside a valid reply
   `OWRR_ASSERT_NOW(a_data_zero, clock, reset, rsp_valid && !rsp_reply_valid, rsp_reply_data == '0, "reply data nonzero without reply")
   // a released line always carries the high pull level
   `OWRR_ASSERT_NOW(a_release_high, clock, reset, rsp_valid && !rsp_line_output_enable, rsp_line_level && rsp_busy_res, "released line not high")

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the one-wire request/reply master: a cycle-free
// model of the tick sequencer predicts the line controls, busy flag and
// reply for every request word; directed restarts and idle ticks come
// first, then random well-formed exchanges mixed with noise under four
// sender/receiver idling mixes
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // field widths taken from the package
   localparam int BYTE_W  = owrr_pkg::BYTE_W;
   localparam int SHIFT_W = owrr_pkg::SHIFT_W;
   localparam int CNT_W   = owrr_pkg::CNT_W;

   // ticks from a start word until the sequencer is back in idle:
   // start tick, request bits, wait ticks, reply bits, stop ticks
   localparam int FULL_TICKS = 1 + owrr_pkg::REQUEST_BITS_DEF + 2
                               + owrr_pkg::REPLY_BITS_DEF + 2;
   // cycles without any handshake before the run is declared hung
   localparam int HANG_LIMIT = 2000;
   // request words per random idling phase
   localparam int PHASE_WORDS = 385;

   // sequencer phases of the model
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_REQUEST,
      SEQ_WAIT,
      SEQ_REPLY,
      SEQ_STOP
   } seq_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, all known from time zero
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic              req_opcode       = owrr_pkg::OP_TICK;
   logic [BYTE_W-1:0] req_request_byte = '0;
   logic              req_line_sample  = 1'b0;

   // response channel
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_line_level;
   logic               rsp_line_output_enable;
   logic               rsp_busy_res;
   logic               rsp_reply_valid;
   logic [SHIFT_W-1:0] rsp_reply_data;

   // model state of the line master
   seq_phase_type      seq_phase = SEQ_IDLE;
   logic [CNT_W-1:0]   seq_count = '0;
   logic [SHIFT_W-1:0] seq_shift = '0;
   logic               seq_level = 1'b1;
   logic               seq_drive = 1'b1;

   // line states owed by the block, oldest first
   owrr_pkg::result_type owed_line_states[$];

   // idling knobs, percent of cycles
   int gap_pct   = 0;
   int stall_pct = 0;

   int words_sent   = 0;
   int fault_count  = 0;
   int stuck_cycles = 0;

   one_wire_request_reply_master_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_opcode             (req_opcode),
      .req_request_byte       (req_request_byte),
      .req_line_sample        (req_line_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_line_level         (rsp_line_level),
      .rsp_line_output_enable (rsp_line_output_enable),
      .rsp_busy_res           (rsp_busy_res),
      .rsp_reply_valid        (rsp_reply_valid),
      .rsp_reply_data         (rsp_reply_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // crc-8 fed one data bit at a time, msb first
   function automatic logic [BYTE_W-1:0] request_crc(
         input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      logic              fb;
      r = owrr_pkg::CRC_INIT;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = r[BYTE_W-1] ^ data[i];
         r  = {r[BYTE_W-2:0], 1'b0};
         if (fb) begin
            r = r ^ owrr_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   // advance the model by one request word and return the line state after it
   function automatic owrr_pkg::result_type advance_exchange(
         input logic op, input logic [BYTE_W-1:0] data, input logic sample);
      owrr_pkg::result_type r;
      r = '0;
      if (op == owrr_pkg::OP_START) begin
         // a start always restarts, even in the middle of an exchange
         seq_phase = SEQ_START;
         seq_shift = {data, request_crc(data), 16'h0000};
         seq_count = owrr_pkg::START_TICKS;
         seq_drive = 1'b1;
         seq_level = 1'b0;
      end else begin
         // counter runs on every tick, wrapping in idle
         seq_count = seq_count - CNT_W'(1);
         case (seq_phase)
            SEQ_START: begin
               if (seq_count == '0) begin
                  seq_count = CNT_W'(owrr_pkg::REQUEST_BITS_DEF);
                  seq_phase = SEQ_REQUEST;
               end
            end
            SEQ_REQUEST: begin
               seq_level = seq_shift[SHIFT_W-1];
               seq_shift = seq_shift << 1;
               if (seq_count == '0) begin
                  seq_count = owrr_pkg::WAIT_TICKS;
                  seq_phase = SEQ_WAIT;
               end
            end
            SEQ_WAIT: begin
               if (seq_count == '0) begin
                  seq_count = CNT_W'(owrr_pkg::REPLY_BITS_DEF);
                  seq_phase = SEQ_REPLY;
               end
               // release the line so the slave can answer
               if (seq_count == owrr_pkg::RELEASE_AT) begin
                  seq_drive = 1'b0;
                  seq_level = 1'b1;
               end
            end
            SEQ_REPLY: begin
               seq_shift = {seq_shift[SHIFT_W-2:0], sample};
               if (seq_count == '0) begin
                  seq_count     = owrr_pkg::STOP_TICKS;
                  seq_phase     = SEQ_STOP;
                  seq_level     = 1'b1;
                  seq_drive     = 1'b1;
                  r.reply_valid = 1'b1;
                  r.reply_data  = seq_shift;
               end
            end
            SEQ_STOP: begin
               if (seq_count == '0) begin
                  seq_phase = SEQ_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
      r.line_level         = seq_level;
      r.line_output_enable = seq_drive;
      r.busy_res           = (seq_phase != SEQ_IDLE);
      return r;
   endfunction

   // send one request word; called at a rising edge, returns at the
   // accepting edge with valid still high so back-to-back words need no drop
   task automatic send_word(input logic op, input logic [BYTE_W-1:0] data,
                            input logic sample);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_request_byte <= data;
      req_line_sample  <= sample;
      do @(posedge clock); while (!req_ready);
      owed_line_states.push_back(advance_exchange(op, data, sample));
      words_sent++;
   endtask

   // sender holds off until every owed word has come back
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_line_states.size() != 0);
   endtask

   // ticks while idle only count the counter down, nothing visible changes
   task automatic test_idle_ticks();
      send_word(owrr_pkg::OP_TICK, 8'h00, 1'b0);
      send_word(owrr_pkg::OP_TICK, 8'hFF, 1'b1);
      send_word(owrr_pkg::OP_TICK, 8'h5A, 1'b0);
   endtask

   // start words during the start phase and the request bits, with both
   // byte extremes
   task automatic test_restart_while_busy();
      send_word(owrr_pkg::OP_START, 8'h00, 1'b1);
      send_word(owrr_pkg::OP_TICK, 8'h00, 1'b0);
      send_word(owrr_pkg::OP_START, 8'hFF, 1'b0);
      send_word(owrr_pkg::OP_START, 8'hFF, 1'b1);
      for (int i = 0; i < 4; i++) begin
         send_word(owrr_pkg::OP_TICK, 8'hFF, i[0]);
      end
      send_word(owrr_pkg::OP_START, 8'hA5, 1'b0);
      for (int i = 0; i < 3; i++) begin
         send_word(owrr_pkg::OP_TICK, 8'h3C, 1'b1);
      end
   endtask

   // one exchange with random content; some are cut short by the next start,
   // some end with extra idle ticks
   task automatic run_exchange();
      logic [BYTE_W-1:0] byte_out;
      int                reply_kind;
      int                span;
      int                tail;
      logic              bit_in;
      case ($urandom_range(9))
         0:       byte_out = 8'h00;
         1:       byte_out = 8'hFF;
         default: byte_out = BYTE_W'($urandom_range(255));
      endcase
      reply_kind = $urandom_range(3);
      span       = FULL_TICKS;
      if ($urandom_range(99) < 15) begin
         span = $urandom_range(FULL_TICKS - 1);
      end
      tail = (span == FULL_TICKS) ? $urandom_range(3) : 0;
      send_word(owrr_pkg::OP_START, byte_out, 1'($urandom_range(1)));
      for (int i = 0; i < span + tail; i++) begin
         // all-zero and all-one replies besides random ones
         case (reply_kind)
            0:       bit_in = 1'b0;
            1:       bit_in = 1'b1;
            default: bit_in = 1'($urandom_range(1));
         endcase
         send_word(owrr_pkg::OP_TICK, BYTE_W'($urandom_range(255)), bit_in);
      end
   endtask

   // short burst of unstructured words, mostly ticks
   task automatic run_noise();
      int burst;
      burst = $urandom_range(5, 20);
      for (int i = 0; i < burst; i++) begin
         send_word(($urandom_range(7) == 0) ? owrr_pkg::OP_START : owrr_pkg::OP_TICK,
                   BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   // random exchanges under one idling mix; the mix changes only once the
   // block has handed back everything
   task automatic test_exchanges(input int sender_idle, input int receiver_stall);
      int phase_end;
      drain_pause();
      gap_pct   = sender_idle;
      stall_pct = receiver_stall;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
         if ($urandom_range(9) == 0) begin
            run_noise();
         end else begin
            run_exchange();
         end
      end
   endtask

   // receiver stalls at random per cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic compare_field(input string field, input logic [SHIFT_W-1:0] want,
                                input logic [SHIFT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fault_count++;
      end
   endtask

   // every response word is matched against the oldest owed line state
   always @(posedge clock) begin : check_words
      owrr_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_line_states.size() == 0) begin
            $display("%0t: response word with nothing owed, expected none, actual %h",
                     $time, {rsp_line_level, rsp_line_output_enable, rsp_busy_res,
                             rsp_reply_valid, rsp_reply_data});
            fault_count++;
         end else begin
            want = owed_line_states.pop_front();
            compare_field("line_level", SHIFT_W'(want.line_level),
                          SHIFT_W'(rsp_line_level));
            compare_field("line_output_enable", SHIFT_W'(want.line_output_enable),
                          SHIFT_W'(rsp_line_output_enable));
            compare_field("busy_res", SHIFT_W'(want.busy_res),
                          SHIFT_W'(rsp_busy_res));
            compare_field("reply_valid", SHIFT_W'(want.reply_valid),
                          SHIFT_W'(rsp_reply_valid));
            compare_field("reply_data", want.reply_data, rsp_reply_data);
         end
      end
   end

   // hang detection: no handshake on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_restart_while_busy();
      test_exchanges(0, 0);
      test_exchanges(78, 0);
      test_exchanges(0, 78);
      test_exchanges(18, 18);

      // let the last words out, then a few cycles for anything stray
      drain_pause();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && owed_line_states.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/owrr_pkg.sv
design/owrr_seq.sv
design/one_wire_request_reply_master_top.sv
tb/sv/tb_top.sv
